// ===== src/bpoc_pkg.sv =====
// Shared constants, register codes and types for the bit pattern occurrence counter.
package bpoc_pkg;

   localparam int BYTE_W              = 8;
   localparam int WINDOW_BITS         = 32;
   localparam int MAX_PATTERN_BITS_DEF = 32;
   localparam int LEN_W               = 6;
   localparam int COUNT_W             = 4;
   localparam int TOTAL_W             = 32;
   localparam int CSR_DATA_W          = 32;
   localparam int CSR_IDX_W           = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BITS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = 1'd1;

   localparam logic [BYTE_W-1:0] BYTE_MSB = 8'h80;

   // Per-cell control: shift the chain by one byte, and drop what the
   // neighbor hands over (start of a new stream).
   typedef struct packed {
      logic advance;
      logic kill;
   } cell_ctrl_type;

endpackage

// ===== src/bpoc_cell.sv =====
// One byte cell of the history chain: holds a byte and its valid flag.
module bpoc_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  bpoc_pkg::cell_ctrl_type      ctrl,
   input  logic [bpoc_pkg::BYTE_W-1:0]  d_in,
   input  logic                         v_in,
   output logic [bpoc_pkg::BYTE_W-1:0]  q,
   output logic                         v
);
   import bpoc_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;
   logic              valid_ff;
   logic              valid_in;

   always_comb begin
      byte_in  = byte_ff;
      valid_in = valid_ff;
      if (ctrl.advance) begin
         byte_in  = d_in;
         valid_in = v_in & ~ctrl.kill;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign q = byte_ff;
   assign v = valid_ff;

endmodule

// ===== src/bpoc_match.sv =====
// Compares the pattern against the eight windows that end in the new byte.
module bpoc_match #(
   parameter int CAP       = bpoc_pkg::WINDOW_BITS,
   parameter int NUM_CELLS = 4
) (
   input  logic [bpoc_pkg::BYTE_W-1:0]           data_byte,
   input  logic [bpoc_pkg::BYTE_W*NUM_CELLS-1:0] hist,
   input  logic [NUM_CELLS-1:0]                  hist_real,
   input  logic [CAP-1:0]                        pattern,
   input  logic [CAP-1:0]                        mask,
   input  logic [bpoc_pkg::LEN_W-1:0]            eff_len,
   output logic [bpoc_pkg::BYTE_W-1:0]           flags
);
   import bpoc_pkg::*;

   localparam int W_BITS = BYTE_W * NUM_CELLS + BYTE_W;
   localparam int IDX_W  = $clog2(W_BITS);
   localparam int POS_W  = LEN_W + 1;

   logic [W_BITS-1:0] window;
   logic [W_BITS-1:0] real_bits;
   logic [POS_W-1:0]  pos [BYTE_W];

   assign window = {hist, data_byte};

   always_comb begin
      real_bits = '0;
      real_bits[BYTE_W-1:0] = '1;
      for (int c = 0; c < NUM_CELLS; c++) begin
         real_bits[BYTE_W*(c+1) +: BYTE_W] = {BYTE_W{hist_real[c]}};
      end
   end

   // Offset k is the window ending k bits before the byte's last bit.
   // The oldest compared bit sits eff_len-1 places further back and must be real.
   always_comb begin
      for (int k = 0; k < BYTE_W; k++) begin
         pos[k]   = POS_W'(k) + POS_W'(eff_len) - POS_W'(1);
         flags[k] = (((window[k +: CAP] ^ pattern) & mask) == '0)
                    && real_bits[pos[k][IDX_W-1:0]];
      end
   end

endmodule

// ===== src/bit_pattern_occurrence_counter_core.sv =====
// Top level of the bit pattern occurrence counter: cell chain, match stage, total stage.
//
//   Channel | Direction | Handshake             | Payload
//   req     | in        | req_valid / req_ready | req_data_byte, req_start_req
//   rsp     | out       | rsp_valid / rsp_ready | rsp_matches_in_byte, rsp_match_total
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// One byte per clock while rsp_ready keeps up; a result passes the match register, then the result register.
// The byte cells shift at accept; match flags are registered, then counted and added
// to the saturating total in the result register.
// Synchronous reset clears the chain's valid flags, the total and both stage valids;
// pattern resets to zero and length to one. csr_ready is always high.
// A held result stalls only when the match stage is also full.
module bit_pattern_occurrence_counter_core #(
   parameter int MAX_PATTERN_BITS = bpoc_pkg::MAX_PATTERN_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bpoc_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic                               req_start_req,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bpoc_pkg::COUNT_W-1:0]       rsp_matches_in_byte,
   output logic [bpoc_pkg::TOTAL_W-1:0]       rsp_match_total,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bpoc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpoc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bpoc_pkg::*;

   localparam int CAP       = (MAX_PATTERN_BITS < WINDOW_BITS) ? MAX_PATTERN_BITS
                                                               : WINDOW_BITS;
   localparam int NUM_CELLS = (CAP - 1 + BYTE_W - 1) / BYTE_W;
   localparam int HIST_W    = BYTE_W * NUM_CELLS;

   // ---------------- configuration ----------------
   logic [CAP-1:0]   pattern_ff, pattern_in;
   logic [CAP-1:0]   mask_ff, mask_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] wr_len;

   assign csr_ready = 1'b1;

   always_comb begin
      wr_len = csr_wdata[LEN_W-1:0];
      if (wr_len == '0) begin
         wr_len = LEN_W'(1);
      end else if (wr_len > LEN_W'(CAP)) begin
         wr_len = LEN_W'(CAP);
      end
   end

   always_comb begin
      pattern_in = pattern_ff;
      mask_in    = mask_ff;
      len_in     = len_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_BITS: begin
               pattern_in = csr_wdata[CAP-1:0];
            end
            CSR_PATTERN_LEN: begin
               len_in = wr_len;
               for (int i = 0; i < CAP; i++) begin
                  mask_in[i] = (LEN_W'(i) < wr_len);
               end
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         mask_ff    <= CAP'(1);
         len_ff     <= LEN_W'(1);
      end else begin
         pattern_ff <= pattern_in;
         mask_ff    <= mask_in;
         len_ff     <= len_in;
      end
   end

   // ---------------- handshake ----------------
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_adv, s1_adv, accept;

   assign out_adv   = ~out_valid_ff | rsp_ready;
   assign s1_adv    = ~s1_valid_ff | out_adv;
   assign req_ready = s1_adv;
   assign accept    = req_valid & req_ready;

   // ---------------- cell chain ----------------
   logic [BYTE_W-1:0]    cell_q [NUM_CELLS];
   logic [NUM_CELLS-1:0] cell_v;
   logic [HIST_W-1:0]    hist;
   logic [NUM_CELLS-1:0] hist_real;

   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      cell_ctrl_type    ctrl;
      logic [BYTE_W-1:0] d_in;
      logic              v_in;

      if (c == 0) begin : g_head
         assign d_in      = req_data_byte;
         assign v_in      = 1'b1;
         assign ctrl.kill = 1'b0;
      end else begin : g_body
         assign d_in      = cell_q[c-1];
         assign v_in      = cell_v[c-1];
         assign ctrl.kill = req_start_req;
      end
      assign ctrl.advance = accept;

      bpoc_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .d_in  (d_in),
         .v_in  (v_in),
         .q     (cell_q[c]),
         .v     (cell_v[c])
      );

      assign hist[BYTE_W*c +: BYTE_W] = cell_q[c];
      // drop history for a byte that starts a new stream
      assign hist_real[c] = cell_v[c] & ~req_start_req;
   end

   // ---------------- match stage ----------------
   logic [BYTE_W-1:0] flags;
   logic [BYTE_W-1:0] flags_ff, flags_in;
   logic              start_ff, start_in;

   bpoc_match #(
      .CAP       (CAP),
      .NUM_CELLS (NUM_CELLS)
   ) u_match (
      .data_byte (req_data_byte),
      .hist      (hist),
      .hist_real (hist_real),
      .pattern   (pattern_ff),
      .mask      (mask_ff),
      .eff_len   (len_ff),
      .flags     (flags)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      flags_in    = flags_ff;
      start_in    = start_ff;
      if (s1_adv) begin
         s1_valid_in = req_valid;
         flags_in    = flags;
         start_in    = req_start_req;
      end
   end

   // ---------------- total stage ----------------
   logic [COUNT_W-1:0] count;
   logic [TOTAL_W:0]   sum;
   logic [TOTAL_W-1:0] base;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   always_comb begin
      count = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         count = count + COUNT_W'(flags_ff[i]);
      end
      base = start_ff ? '0 : total_ff;
      sum  = {1'b0, base} + (TOTAL_W + 1)'(count);
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      if (out_adv) begin
         out_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            count_in = count;
            // hold at all ones once the total overflows
            total_in = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
      start_ff <= start_in;
      count_ff <= count_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_matches_in_byte = count_ff;
   assign rsp_match_total     = total_ff;

endmodule

// ===== src/bpoc_checker.sv =====
// Port-level checker for the bit pattern occurrence counter, bound to the top level.
module bpoc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [bpoc_pkg::BYTE_W-1:0]        req_data_byte,
   input logic                               req_start_req,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [bpoc_pkg::COUNT_W-1:0]       rsp_matches_in_byte,
   input logic [bpoc_pkg::TOTAL_W-1:0]       rsp_match_total,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic [bpoc_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [bpoc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bpoc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_matches_in_byte)
                                 && $stable(rsp_match_total))
      else $error("result changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_matches_in_byte <= COUNT_W'(BYTE_W))
      else $error("more matches than bits in a byte");

   a_total_covers_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_match_total >= TOTAL_W'(rsp_matches_in_byte))
      else $error("total below the byte's own match count");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port not ready");

endmodule

bind bit_pattern_occurrence_counter_core bpoc_checker u_bpoc_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the bit pattern occurrence counter core.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bpoc_pkg::*;

   localparam int BYTE_TARGET = 2000;
   localparam int STALL_LIMIT = 500;
   localparam int LEN_CAP     = (MAX_PATTERN_BITS_DEF < WINDOW_BITS) ?
                                MAX_PATTERN_BITS_DEF : WINDOW_BITS;

   typedef struct packed {
      logic [COUNT_W-1:0] hits;
      logic [TOTAL_W-1:0] total;
   } byte_result_type;

   typedef struct {
      logic [31:0] pat;
      logic [31:0] len_word;
      logic [7:0]  data;
      logic        start;
      logic        fixed;
      logic [3:0]  cnt;
      logic [31:0] tot;
   } scan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_data_byte = '0;
   logic                  req_start_req = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [COUNT_W-1:0]    rsp_matches_in_byte;
   logic [TOTAL_W-1:0]    rsp_match_total;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Typed-in expectation that travels with the item on the wire
   logic                  row_fixed = 1'b0;
   logic [COUNT_W-1:0]    row_cnt = '0;
   logic [TOTAL_W-1:0]    row_tot = '0;

   // Predictor copy of the block's registers and state
   logic [31:0]           cfg_pattern = '0;
   logic [5:0]            cfg_len = 6'd1;
   logic [30:0]           stream_hist = '0;
   logic [5:0]            stream_bits_seen = '0;
   logic [31:0]           stream_total = '0;

   byte_result_type       pending_results[$];
   scan_row_type          scan_rows[$];

   logic                  tx_burst = 1'b0;
   logic                  rx_burst = 1'b0;
   int                    errors = 0;
   int                    bytes_sent = 0;
   int                    results_checked = 0;
   int                    settings_used = 0;
   longint                matches_seen = 0;
   int                    idle_cycles = 0;

   bit_pattern_occurrence_counter_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_start_req      (req_start_req),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_matches_in_byte(rsp_matches_in_byte),
      .rsp_match_total    (rsp_match_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int eff_len();
      int n;
      n = int'(cfg_len);
      if (n < 1) n = 1;
      if (n > LEN_CAP) n = LEN_CAP;
      return n;
   endfunction

   // Shift one byte into the history, MSB first, and count window hits.
   function automatic byte_result_type scan_byte(input logic [7:0] b, input logic s);
      int              n;
      logic [31:0]     lmask;
      logic [31:0]     pat;
      logic [31:0]     window;
      logic [3:0]      cnt;
      byte_result_type r;
      n = eff_len();
      lmask = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
      pat = cfg_pattern & lmask;
      cnt = '0;
      if (s) begin
         stream_hist = '0;
         stream_bits_seen = '0;
         stream_total = '0;
      end
      for (int i = 7; i >= 0; i--) begin
         window = {stream_hist, b[i]};
         stream_hist = window[30:0];
         if (stream_bits_seen < 6'd32) stream_bits_seen = stream_bits_seen + 6'd1;
         if (int'(stream_bits_seen) >= n && (window & lmask) == pat) cnt = cnt + 4'd1;
      end
      if (stream_total > 32'hFFFF_FFFF - 32'(cnt)) stream_total = 32'hFFFF_FFFF;
      else stream_total = stream_total + 32'(cnt);
      r.hits = cnt;
      r.total = stream_total;
      return r;
   endfunction

   function automatic void add_row(input logic [31:0] pat, input logic [31:0] len_word,
                                   input logic [7:0] data, input logic start,
                                   input logic fixed, input logic [3:0] cnt,
                                   input logic [31:0] tot);
      scan_row_type r;
      r.pat = pat;
      r.len_word = len_word;
      r.data = data;
      r.start = start;
      r.fixed = fixed;
      r.cnt = cnt;
      r.tot = tot;
      scan_rows.push_back(r);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic s, input logic fixed,
                            input logic [3:0] cnt, input logic [31:0] tot);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_start_req <= s;
      row_fixed <= fixed;
      row_cnt <= cnt;
      row_tot <= tot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Drop valid, wait for every result, then let the pipeline go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (results_checked != bytes_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_PATTERN_BITS) cfg_pattern = value;
      else cfg_len = value[5:0];
   endtask

   task automatic load_pattern(input logic [31:0] pat, input logic [31:0] len_word);
      settle();
      write_reg(CSR_PATTERN_BITS, pat);
      write_reg(CSR_PATTERN_LEN, len_word);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Result checker and predictor, both on accepted items
   always @(posedge clock) begin : scoreboard
      byte_result_type got;
      byte_result_type want;
      byte_result_type pred;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.hits = rsp_matches_in_byte;
            got.total = rsp_match_total;
            if (pending_results.size() == 0) begin
               $error("result with no byte outstanding: matches_in_byte %0d match_total %0d",
                      got.hits, got.total);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (got.hits !== want.hits) begin
                  $error("matches_in_byte: expected %0d, actual %0d", want.hits, got.hits);
                  errors++;
               end
               if (got.total !== want.total) begin
                  $error("match_total: expected %0d, actual %0d", want.total, got.total);
                  errors++;
               end
               results_checked++;
               matches_seen += want.hits;
            end
         end
         if (req_valid && req_ready) begin
            pred = scan_byte(req_data_byte, req_start_req);
            if (row_fixed) begin
               want.hits = row_cnt;
               want.total = row_tot;
               pending_results.push_back(want);
            end else begin
               pending_results.push_back(pred);
            end
         end
      end
   end

   // Result side: hold off ready for a drawn number of cycles after each item
   initial begin : receiver
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_ready && rsp_valid) begin
            hold = rx_burst ? 0 : $urandom_range(0, 7);
            if (hold != 0) rsp_ready <= 1'b0;
         end else if (!rsp_ready) begin
            if (hold == 0) rsp_ready <= 1'b1;
            else hold--;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_top: no progress for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, pending_results.size());
         $display("tb_top: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [31:0] cur_pat;
      logic [31:0] cur_len;
      logic [31:0] pat_word;
      logic [31:0] len_word;
      logic [7:0]  b;
      logic        s;
      logic        feed[$];
      int          n;
      int          flip;
      int          pick;

      // Reset loads pattern zero, length one
      add_row(32'h0, 32'd1, 8'h00, 1'b0, 1'b1, 4'd8, 32'd8);
      add_row(32'h0, 32'd1, 8'hFF, 1'b0, 1'b1, 4'd0, 32'd8);
      add_row(32'h0, 32'd1, 8'hA5, 1'b1, 1'b1, 4'd4, 32'd4);
      add_row(32'h0, 32'd1, 8'h5A, 1'b0, 1'b0, 4'd0, 32'd0);
      add_row(32'hFF, 32'd8, 8'hFF, 1'b1, 1'b1, 4'd1, 32'd1);
      add_row(32'hFF, 32'd8, 8'hFF, 1'b0, 1'b1, 4'd8, 32'd9);
      add_row(32'hFF, 32'd8, 8'h7F, 1'b0, 1'b0, 4'd0, 32'd0);
      // Full-width pattern: nothing counts until 32 bits are in
      add_row(32'hFFFF_FFFF, 32'd32, 8'hFF, 1'b1, 1'b1, 4'd0, 32'd0);
      add_row(32'hFFFF_FFFF, 32'd32, 8'hFF, 1'b0, 1'b1, 4'd0, 32'd0);
      add_row(32'hFFFF_FFFF, 32'd32, 8'hFF, 1'b0, 1'b1, 4'd0, 32'd0);
      add_row(32'hFFFF_FFFF, 32'd32, 8'hFF, 1'b0, 1'b1, 4'd1, 32'd1);
      add_row(32'hFFFF_FFFF, 32'd32, 8'hFF, 1'b0, 1'b1, 4'd8, 32'd9);
      add_row(32'hFFFF_FFFF, 32'd32, 8'hFE, 1'b0, 1'b0, 4'd0, 32'd0);
      // Zero length behaves as one bit
      add_row(32'h1, 32'd0, 8'hF0, 1'b1, 1'b1, 4'd4, 32'd4);
      // Oversized length clamps to the window
      add_row(32'h0, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b1, 4'd0, 32'd0);
      add_row(32'h0, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1, 4'd0, 32'd0);
      add_row(32'h0, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1, 4'd0, 32'd0);
      add_row(32'h0, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1, 4'd1, 32'd1);
      add_row(32'h0, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1, 4'd8, 32'd9);
      // Pattern bits above the length are ignored; overlapping hits
      add_row(32'hFFFF_FF05, 32'd4, 8'h55, 1'b1, 1'b1, 4'd3, 32'd3);
      add_row(32'hFFFF_FF05, 32'd4, 8'h55, 1'b0, 1'b0, 4'd0, 32'd0);
      // Match straddling a byte boundary
      add_row(32'h3C, 32'd8, 8'h03, 1'b1, 1'b1, 4'd0, 32'd0);
      add_row(32'h3C, 32'd8, 8'hC0, 1'b0, 1'b1, 4'd1, 32'd1);
      add_row(32'h3C, 32'd8, 8'h3C, 1'b1, 1'b0, 4'd0, 32'd0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      cur_pat = 32'h0;
      cur_len = 32'd1;
      settings_used = 1;
      foreach (scan_rows[i]) begin
         if (scan_rows[i].pat != cur_pat || scan_rows[i].len_word != cur_len) begin
            load_pattern(scan_rows[i].pat, scan_rows[i].len_word);
            cur_pat = scan_rows[i].pat;
            cur_len = scan_rows[i].len_word;
         end
         send_byte(scan_rows[i].data, scan_rows[i].start, scan_rows[i].fixed,
                   scan_rows[i].cnt, scan_rows[i].tot);
      end

      while (bytes_sent < BYTE_TARGET) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       n = 0;
            1:       n = $urandom_range(33, 63);
            2:       n = 32;
            3, 4:    n = $urandom_range(9, 31);
            default: n = $urandom_range(1, 8);
         endcase
         len_word = $urandom();
         len_word[5:0] = n[5:0];
         pat_word = $urandom();
         load_pattern(pat_word, len_word);
         tx_burst = ($urandom_range(0, 3) == 0);
         rx_burst = ($urandom_range(0, 3) == 0);
         feed.delete();
         repeat ($urandom_range(40, 160)) begin
            if ($urandom_range(0, 7) == 0) begin
               b = 8'($urandom_range(0, 255));
            end else begin
               // Build the stream from pattern copies, some corrupted, and random filler
               while (feed.size() < 8) begin
                  if ($urandom_range(0, 2) != 0) begin
                     flip = ($urandom_range(0, 5) == 0) ? $urandom_range(0, eff_len() - 1) : -1;
                     for (int k = eff_len() - 1; k >= 0; k--) begin
                        feed.push_back(cfg_pattern[k] ^ (k == flip));
                     end
                  end else begin
                     repeat ($urandom_range(1, 9)) feed.push_back(1'($urandom_range(0, 1)));
                  end
               end
               for (int j = 7; j >= 0; j--) b[j] = feed.pop_front();
            end
            s = ($urandom_range(0, 31) == 0);
            send_byte(b, s, 1'b0, 4'd0, 32'd0);
         end
      end

      req_valid <= 1'b0;
      while (results_checked != bytes_sent) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("tb_top: %0d bytes scanned under %0d pattern settings", bytes_sent, settings_used);
      $display("tb_top: %0d results checked, %0d matches counted", results_checked, matches_seen);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ===== bit_pattern_occurrence_counter_core.f =====
src/bpoc_pkg.sv
src/bpoc_cell.sv
src/bpoc_match.sv
src/bit_pattern_occurrence_counter_core.sv
src/bpoc_checker.sv
test/tb_top.sv
